>>> hw/rtl/polynomial_table_arithmetic_defines.svh
// ----------------------------------------------------------------------------
// Polynomial table arithmetic assertion macros
// Shared helpers for the concurrent checks in the RTL modules.
// ----------------------------------------------------------------------------
`ifndef POLYNOMIAL_TABLE_ARITHMETIC_DEFINES_SVH
`define POLYNOMIAL_TABLE_ARITHMETIC_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PTA_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PTA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/pta_pkg.sv
// ----------------------------------------------------------------------------
// Polynomial table arithmetic package
// Sizes, operation and status codes, controller states and command types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pta_pkg;

  localparam int MAX_POLYS  = 8;
  localparam int MAX_DEGREE = 31;
  localparam int SLOT_W     = 3;
  localparam int POW_W      = 5;
  localparam int CNT_W      = $clog2(MAX_POLYS + 1);
  localparam int ADDR_W     = SLOT_W + POW_W;
  localparam int DATA_W     = 32;
  localparam int COEF_DEPTH = MAX_POLYS * (MAX_DEGREE + 1);

  typedef enum logic [2:0] {
    OP_CREATE = 3'd0,
    OP_WRITE  = 3'd1,
    OP_EVAL   = 3'd2,
    OP_ADD    = 3'd3,
    OP_MUL    = 3'd4,
    OP_READ   = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_FULL      = 2'd2,
    ST_DEGREE    = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DEG,
    S_RUN,
    S_DRAIN,
    S_DONE
  } state_e;

  typedef struct packed {
    logic capture;
    logic start;
    logic run;
    logic finish;
    logic fail;
  } cmd_t;

  typedef struct packed {
    status_e err;
    logic    issue_final;
    logic    pipe_empty;
  } sts_t;

endpackage

>>> hw/rtl/pta_req_if.sv
// ----------------------------------------------------------------------------
// Polynomial table request channel
// Valid/ready channel carrying one operation per transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pta_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  operation;
  logic [2:0]  first_poly;
  logic [2:0]  second_poly;
  logic [4:0]  power;
  logic signed [31:0] operand_value;

  modport source (output valid, operation, first_poly, second_poly, power, operand_value,
                  input ready);
  modport sink (input valid, operation, first_poly, second_poly, power, operand_value,
                output ready);
endinterface

>>> hw/rtl/pta_rsp_if.sv
// ----------------------------------------------------------------------------
// Polynomial table response channel
// Valid/ready channel carrying one result per transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pta_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic signed [31:0] result_value;
  logic [4:0]  result_degree;
  logic [2:0]  result_slot;

  modport source (output valid, status, result_value, result_degree, result_slot,
                  input ready);
  modport sink (input valid, status, result_value, result_degree, result_slot,
                output ready);
endinterface

>>> hw/rtl/pta_ctrl.sv
// ----------------------------------------------------------------------------
// Polynomial table controller
// Sequences capture, check, term issue, drain and result hand-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "polynomial_table_arithmetic_defines.svh"

module pta_ctrl import pta_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output cmd_t cmd_o,
  input  sts_t sts_i
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DEG;
        end
      end
      S_DEG: begin
        if (sts_i.err != ST_OK) begin
          cmd_o.fail = 1'b1;
          state_d    = S_DONE;
        end else begin
          cmd_o.start = 1'b1;
          state_d     = S_RUN;
        end
      end
      S_RUN: begin
        cmd_o.run = 1'b1;
        if (sts_i.issue_final) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (sts_i.pipe_empty) begin
          cmd_o.finish = 1'b1;
          state_d      = S_DONE;
        end
      end
      S_DONE: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  `PTA_ASSERT_NOW(a_no_overlap, clk_i, rst_ni, in_ready_o, !out_valid_o, "request taken while busy")
  `PTA_ASSERT_NEXT(a_fail_to_done, clk_i, rst_ni, cmd_o.fail, out_valid_o, "failed check not answered")
  `PTA_ASSERT_NEXT(a_rsp_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o, "response dropped")

endmodule

>>> hw/rtl/pta_dpath.sv
// ----------------------------------------------------------------------------
// Polynomial table datapath
// Coefficient and degree stores, term sequencer and multiply-accumulate pipe.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "polynomial_table_arithmetic_defines.svh"

module pta_dpath import pta_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  output sts_t              sts_o,
  input  logic [2:0]        operation_i,
  input  logic [SLOT_W-1:0] first_poly_i,
  input  logic [SLOT_W-1:0] second_poly_i,
  input  logic [POW_W-1:0]  power_i,
  input  logic [DATA_W-1:0] operand_value_i,
  output logic [1:0]        status_o,
  output logic [DATA_W-1:0] result_value_o,
  output logic [POW_W-1:0]  result_degree_o,
  output logic [SLOT_W-1:0] result_slot_o
);

  logic [DATA_W-1:0] coef_mem [COEF_DEPTH];
  logic [POW_W-1:0]  deg_mem  [MAX_POLYS];

  logic [CNT_W-1:0]  count_q;
  logic [CNT_W-1:0]  count_m1;
  logic [SLOT_W-1:0] newest_slot, count_slot;

  logic [2:0]        op_q;
  logic [SLOT_W-1:0] pa_q, pb_q, dst_q;
  logic [POW_W-1:0]  pw_q, deg_a_q, deg_b_q, dr_q;
  logic [DATA_W-1:0] x_q;
  logic [SLOT_W-1:0] deg_addr_a;

  logic [POW_W:0]    dr_sum;
  logic [POW_W-1:0]  dr_w;
  status_e           err;

  logic [POW_W-1:0]  n_q, k_q, n_d, k_d, n_inc;
  logic [POW_W-1:0]  klo, khi, klo_next, ka, kb;
  logic              t_first, t_last, t_final, t_use_a, t_use_b;
  logic [ADDR_W-1:0] addr_a, addr_b;

  logic              v1_q, first1_q, last1_q, use_a1_q, use_b1_q;
  logic [POW_W-1:0]  n1_q;
  logic [DATA_W-1:0] ra_q, rb_q;

  logic              v2_q, first2_q, last2_q;
  logic [POW_W-1:0]  n2_q;
  logic [DATA_W-1:0] prod_q, sum_q, ra2_q;
  logic [2*DATA_W-1:0] prod_full;

  logic [DATA_W-1:0] acc_q, base, value_next;
  logic [2*DATA_W-1:0] eval_full;
  logic              wr_en, op_writes;

  logic [1:0]        status_q;
  logic [DATA_W-1:0] value_q;
  logic [POW_W-1:0]  rdeg_q;
  logic [SLOT_W-1:0] rslot_q;

  assign count_m1    = count_q - 1'b1;
  assign newest_slot = count_m1[SLOT_W-1:0];
  assign count_slot  = count_q[SLOT_W-1:0];
  assign deg_addr_a  = (op_e'(operation_i) == OP_WRITE) ? newest_slot : first_poly_i;

  // Capture the request and fetch both operand degrees.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q    <= operation_i;
      pa_q    <= first_poly_i;
      pb_q    <= second_poly_i;
      pw_q    <= power_i;
      x_q     <= operand_value_i;
      deg_a_q <= deg_mem[deg_addr_a];
      deg_b_q <= deg_mem[second_poly_i];
    end
  end

  // Result degree of a producing operation.
  always_comb begin
    case (op_e'(op_q))
      OP_ADD:  dr_sum = (deg_a_q > deg_b_q) ? {1'b0, deg_a_q} : {1'b0, deg_b_q};
      OP_MUL:  dr_sum = {1'b0, deg_a_q} + {1'b0, deg_b_q};
      default: dr_sum = {1'b0, pw_q};
    endcase
  end
  assign dr_w = dr_sum[POW_W-1:0];

  always_comb begin
    err = ST_OK;
    case (op_e'(op_q))
      OP_CREATE: begin
        if (count_q == CNT_W'(MAX_POLYS)) err = ST_FULL;
        else if (int'(pw_q) > MAX_DEGREE) err = ST_DEGREE;
      end
      OP_WRITE: begin
        if (count_q == '0 || pw_q > deg_a_q) err = ST_BAD_INDEX;
      end
      OP_EVAL: begin
        if ({1'b0, pa_q} >= count_q) err = ST_BAD_INDEX;
      end
      OP_ADD, OP_MUL: begin
        if ({1'b0, pa_q} >= count_q || {1'b0, pb_q} >= count_q) err = ST_BAD_INDEX;
        else if (count_q == CNT_W'(MAX_POLYS)) err = ST_FULL;
        else if (int'(dr_sum) > MAX_DEGREE) err = ST_DEGREE;
      end
      OP_READ: begin
        if ({1'b0, pa_q} >= count_q || pw_q > deg_a_q) err = ST_BAD_INDEX;
      end
      default: err = ST_BAD_INDEX;
    endcase
  end

  // Term sequencer: one memory access pair per cycle while running.
  assign n_inc    = n_q + 1'b1;
  assign klo      = (n_q > deg_b_q) ? n_q - deg_b_q : '0;
  assign khi      = (n_q < deg_a_q) ? n_q : deg_a_q;
  assign klo_next = (n_inc > deg_b_q) ? n_inc - deg_b_q : '0;

  always_comb begin
    t_first = 1'b1;
    t_last  = 1'b1;
    t_final = 1'b1;
    t_use_a = 1'b1;
    t_use_b = 1'b1;
    ka      = n_q;
    kb      = n_q;
    n_d     = n_q;
    k_d     = k_q;
    case (op_e'(op_q))
      OP_CREATE, OP_ADD: begin
        t_final = (n_q == dr_q);
        t_use_a = (n_q <= deg_a_q);
        t_use_b = (n_q <= deg_b_q);
        n_d     = n_inc;
      end
      OP_EVAL: begin
        t_first = (k_q == deg_a_q);
        t_last  = (k_q == '0);
        t_final = t_last;
        ka      = k_q;
        k_d     = k_q - 1'b1;
      end
      OP_MUL: begin
        t_first = (k_q == klo);
        t_last  = (k_q == khi);
        t_final = t_last && (n_q == dr_q);
        ka      = k_q;
        kb      = n_q - k_q;
        if (t_last) begin
          n_d = n_inc;
          k_d = klo_next;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      default: begin
        ka = pw_q;
      end
    endcase
  end

  assign addr_a = {pa_q, ka};
  assign addr_b = {pb_q, kb};

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      dr_q  <= dr_w;
      dst_q <= (op_e'(op_q) == OP_WRITE) ? newest_slot : count_slot;
      n_q   <= (op_e'(op_q) == OP_WRITE) ? pw_q : '0;
      case (op_e'(op_q))
        OP_EVAL: k_q <= deg_a_q;
        default: k_q <= '0;
      endcase
    end else if (cmd_i.run) begin
      n_q <= n_d;
      k_q <= k_d;
    end
  end

  // Pipeline valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.run;
      v2_q <= v1_q;
    end
  end

  // Coefficient store: one write port, two registered read ports.
  always_ff @(posedge clk_i) begin
    ra_q <= coef_mem[addr_a];
    rb_q <= coef_mem[addr_b];
    if (wr_en) begin
      coef_mem[{dst_q, n2_q}] <= value_next;
    end
  end

  assign prod_full = {{DATA_W{1'b0}}, ra_q} * {{DATA_W{1'b0}}, rb_q};

  always_ff @(posedge clk_i) begin
    first1_q <= t_first;
    last1_q  <= t_last;
    use_a1_q <= t_use_a;
    use_b1_q <= t_use_b;
    n1_q     <= (op_e'(op_q) == OP_MUL || op_e'(op_q) == OP_ADD ||
                 op_e'(op_q) == OP_CREATE) ? n_q : pw_q;
    first2_q <= first1_q;
    last2_q  <= last1_q;
    n2_q     <= n1_q;
    prod_q   <= prod_full[DATA_W-1:0];
    sum_q    <= (use_a1_q ? ra_q : '0) + (use_b1_q ? rb_q : '0);
    ra2_q    <= ra_q;
  end

  // Accumulate stage; Horner steps share the same accumulator.
  assign base      = first2_q ? '0 : acc_q;
  assign eval_full = {{DATA_W{1'b0}}, base} * {{DATA_W{1'b0}}, x_q};

  always_comb begin
    case (op_e'(op_q))
      OP_MUL:   value_next = base + prod_q;
      OP_EVAL:  value_next = eval_full[DATA_W-1:0] + ra2_q;
      OP_ADD:   value_next = sum_q;
      OP_WRITE: value_next = x_q;
      OP_READ:  value_next = ra2_q;
      default:  value_next = '0;
    endcase
  end

  assign op_writes = (op_e'(op_q) == OP_CREATE) || (op_e'(op_q) == OP_WRITE) ||
                     (op_e'(op_q) == OP_ADD) || (op_e'(op_q) == OP_MUL);
  assign wr_en     = v2_q && last2_q && op_writes;

  always_ff @(posedge clk_i) begin
    if (v2_q) begin
      acc_q <= value_next;
    end
  end

  // Table occupancy and degree store.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.finish && op_writes && op_e'(op_q) != OP_WRITE) begin
      count_q <= count_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish && op_writes && op_e'(op_q) != OP_WRITE) begin
      deg_mem[count_slot] <= dr_q;
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.fail) begin
      status_q <= err;
      value_q  <= '0;
      rdeg_q   <= '0;
      rslot_q  <= '0;
    end else if (cmd_i.finish) begin
      status_q <= ST_OK;
      value_q  <= (op_e'(op_q) == OP_EVAL || op_e'(op_q) == OP_READ) ? acc_q : '0;
      case (op_e'(op_q))
        OP_CREATE, OP_ADD, OP_MUL: begin
          rdeg_q  <= dr_q;
          rslot_q <= count_slot;
        end
        OP_WRITE: begin
          rdeg_q  <= deg_a_q;
          rslot_q <= newest_slot;
        end
        default: begin
          rdeg_q  <= deg_a_q;
          rslot_q <= '0;
        end
      endcase
    end
  end

  assign sts_o.err         = err;
  assign sts_o.issue_final = cmd_i.run && t_final;
  assign sts_o.pipe_empty  = !v1_q && !v2_q;

  assign status_o        = status_q;
  assign result_value_o  = value_q;
  assign result_degree_o = rdeg_q;
  assign result_slot_o   = rslot_q;

  `PTA_ASSERT_NOW(a_count_range, clk_i, rst_ni, 1'b1, count_q <= CNT_W'(MAX_POLYS), "polynomial count beyond table size")
  `PTA_ASSERT_NOW(a_new_slot_free, clk_i, rst_ni, wr_en && op_e'(op_q) != OP_WRITE, count_q < CNT_W'(MAX_POLYS), "new polynomial written into a full table")
  `PTA_ASSERT_NOW(a_pipe_idle, clk_i, rst_ni, cmd_i.capture, !v1_q && !v2_q, "new request while terms still in flight")

endmodule

>>> hw/rtl/polynomial_table_arithmetic.sv
// ----------------------------------------------------------------------------
// Polynomial table arithmetic
// Table of up to eight dense integer polynomials with create, write, read,
// evaluate, add and multiply operations.
//
// Usage: one request transaction on req_i carries one operation; exactly
// one response transaction on rsp_o follows it. One request is in work at a
// time; req_i.ready is high only while the block is idle.
// After acceptance the sequencer issues terms, one per cycle through the
// two-port coefficient store: 1 for write and read, degree + 1 for create,
// add and evaluate, (da + 1) * (db + 1) for multiply; response valid rises
// once the multiply-accumulate pipe has drained. A request that fails its
// checks goes from the check state straight to the response, with no terms.
// Reset empties the table (count zero); stored coefficients are not cleared
// and need no clearing pass. A stalled receiver holds the response; the
// next request is not taken until the response transaction completes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module polynomial_table_arithmetic import pta_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  pta_req_if.sink   req_i,
  pta_rsp_if.source rsp_o
);

  cmd_t cmd;
  sts_t sts;

  pta_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  pta_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .operation_i     (req_i.operation),
    .first_poly_i    (req_i.first_poly),
    .second_poly_i   (req_i.second_poly),
    .power_i         (req_i.power),
    .operand_value_i (req_i.operand_value),
    .status_o        (rsp_o.status),
    .result_value_o  (rsp_o.result_value),
    .result_degree_o (rsp_o.result_degree),
    .result_slot_o   (rsp_o.result_slot)
  );

endmodule
